### rtl/palette_range_depth_shader_unit_defines.svh
`ifndef PALETTE_RANGE_DEPTH_SHADER_UNIT_DEFINES_SVH
`define PALETTE_RANGE_DEPTH_SHADER_UNIT_DEFINES_SVH

// implication checked in the same cycle, off during reset
`define PRDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle, off during reset
`define PRDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked in the next cycle, also during reset
`define PRDS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/prds_pkg.sv
package prds_pkg;

    // table and palette dimensions
    localparam int RANGE_SLOTS = 64;
    localparam int ZONE_COUNT  = 16;
    localparam int COLOR_COUNT = 256;

    // field widths
    localparam int COLOR_W = 8;
    localparam int INDEX_W = 6;
    localparam int ZONE_W  = 4;
    localparam int COUNT_W = 7;

    // wide enough for colour, zone and range end without wrap
    localparam int NARROW_W = 9;
    localparam int ARITH_W  = 11;
    localparam int END_W    = 10;

    // registered priority tree shape
    localparam int GROUP_SIZE = 8;
    localparam int GROUPS     = (RANGE_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int MERGE_FAN  = 4;
    localparam int HALVES     = (GROUPS + MERGE_FAN - 1) / MERGE_FAN;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_COUNT = REG_IDX_W'(0);

    // item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_MAP   = 1'b1;

    // one stored range
    typedef struct packed {
        logic [COLOR_W-1:0]      first;
        logic signed [END_W-1:0] range_end;
        logic                    desc;
        logic [COLOR_W-1:0]      clip;
    } t_range_entry;

    // first stage results: one candidate per group of entries
    typedef struct packed {
        logic [GROUPS-1:0]              hit;
        logic [GROUPS-1:0][COLOR_W-1:0] res;
        logic [COLOR_W-1:0]             color;
    } t_grp_bus;

endpackage

### rtl/prds_if.sv
interface prds_in_if;
    import prds_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [INDEX_W-1:0]        range_index;
    logic [COLOR_W-1:0]        first_color;
    logic signed [COLOR_W-1:0] color_span;
    logic [COLOR_W-1:0]        clip_color;
    logic [COLOR_W-1:0]        pixel_color;
    logic [ZONE_W-1:0]         zone;

    modport source (
        output valid, action, range_index, first_color, color_span, clip_color,
               pixel_color, zone,
        input  ready
    );
    modport sink (
        input  valid, action, range_index, first_color, color_span, clip_color,
               pixel_color, zone,
        output ready
    );
endinterface

interface prds_out_if;
    import prds_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] mapped_color;

    modport source (output valid, mapped_color, input ready);
    modport sink (input valid, mapped_color, output ready);
endinterface

### rtl/palette_range_depth_shader_unit.sv
// Palette range shader: a write item stores one range (first colour, signed span, clip
// colour) in a 64-slot table and gives no result; a map item shades one palette index by
// its distance zone against the first matching range among the first range_count slots.
// One item is taken every clock while the output side is not stalled. A map result passes
// through registered stages: a comparator per table slot and an eight-way pick form the first
// stage, a four-way pick over the groups the second, the final pick and the output
// register the third. A write is visible to every map item accepted after it.
// range_count sits at APB byte address 0 and should only change while no item is in flight.
module palette_range_depth_shader_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    prds_in_if.sink                         i_pix,
    prds_out_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [prds_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [prds_pkg::APB_DATA_W-1:0] pwdata,
    output logic [prds_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import prds_pkg::*;

    logic [COUNT_W-1:0] range_count;
    logic               grp_valid;
    logic               grp_ready;
    t_grp_bus           grp;

    // configuration register
    prds_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_range_count (range_count)
    );

    // range table and first stage
    prds_match u_match (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (i_pix),
        .i_range_count (range_count),
        .o_valid       (grp_valid),
        .o_grp         (grp),
        .i_ready       (grp_ready)
    );

    // priority tree and output register
    prds_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (grp_valid),
        .i_grp   (grp),
        .o_ready (grp_ready),
        .o_res   (o_res)
    );
endmodule

### rtl/prds_cfg.sv
module prds_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [prds_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [prds_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [prds_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [prds_pkg::COUNT_W-1:0]       o_range_count
);
    import prds_pkg::*;

    logic [COUNT_W-1:0]   r_range_count;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_count <= '0;
        end else if (wr_en && reg_idx == REG_RANGE_COUNT) begin
            r_range_count <= pwdata[COUNT_W-1:0];
        end
    end

    // register read
    always_comb begin
        case (reg_idx)
            REG_RANGE_COUNT: prdata = APB_DATA_W'(r_range_count);
            default:         prdata = '0;
        endcase
    end

    assign o_range_count = r_range_count;
endmodule

### rtl/prds_match.sv
module prds_match (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    prds_in_if.sink                   i_pix,
    input  logic [prds_pkg::COUNT_W-1:0] i_range_count,
    output logic                      o_valid,
    output prds_pkg::t_grp_bus        o_grp,
    input  logic                      i_ready
);
    import prds_pkg::*;

    localparam int PAD_SLOTS = GROUPS * GROUP_SIZE;
    localparam logic signed [ARITH_W-1:0] COLOR_MAX = ARITH_W'(COLOR_COUNT - 1);

    logic                      r_valid;
    t_grp_bus                  r_grp;
    t_grp_bus                  n_grp;

    logic                      accept;
    logic                      wr_item;
    logic [NARROW_W-1:0]       slot_ext;
    logic signed [ARITH_W-1:0] wr_first;
    logic signed [ARITH_W-1:0] wr_span;
    logic signed [ARITH_W-1:0] wr_end;
    t_range_entry              wr_entry;

    logic [NARROW_W-1:0]       zone_ext;
    logic [NARROW_W-1:0]       zone_cl;
    logic signed [ARITH_W-1:0] c;
    logic signed [ARITH_W-1:0] z;
    logic signed [ARITH_W-1:0] s_up;
    logic signed [ARITH_W-1:0] s_dn;
    logic                      color_ok;

    logic [PAD_SLOTS-1:0]      ent_hit;
    logic [COLOR_W-1:0]        ent_res [PAD_SLOTS];

    assign i_pix.ready = !r_valid || i_ready;
    assign accept      = i_pix.valid && i_pix.ready;
    assign wr_item     = accept && (i_pix.action == ACT_WRITE);

    // range end worked out once at write time
    assign slot_ext = NARROW_W'(i_pix.range_index);
    assign wr_first = ARITH_W'(i_pix.first_color);
    assign wr_span  = ARITH_W'(i_pix.color_span);
    assign wr_end   = wr_first + wr_span;
    assign wr_entry = '{first:     i_pix.first_color,
                        range_end: END_W'(wr_end),
                        desc:      i_pix.color_span[COLOR_W-1],
                        clip:      i_pix.clip_color};

    // shaded colours, shared by every entry
    assign zone_ext = NARROW_W'(i_pix.zone);
    assign zone_cl  = (zone_ext > NARROW_W'(ZONE_COUNT - 1)) ?
                      NARROW_W'(ZONE_COUNT - 1) : zone_ext;
    assign c        = ARITH_W'(i_pix.pixel_color);
    assign z        = ARITH_W'(zone_cl);
    assign s_up     = c + z;
    assign s_dn     = c - z;
    assign color_ok = NARROW_W'(i_pix.pixel_color) < NARROW_W'(COLOR_COUNT);

    // one cell per table slot: storage and range test
    for (genvar i = 0; i < PAD_SLOTS; i++) begin : g_slot
        if (i < RANGE_SLOTS) begin : g_used
            t_range_entry              r_entry;
            logic signed [ARITH_W-1:0] f;
            logic signed [ARITH_W-1:0] en;
            logic                      active;
            logic                      in_rng;
            logic                      clipped;

            always_ff @(posedge i_clk) begin
                if (wr_item && slot_ext == NARROW_W'(i)) begin
                    r_entry <= wr_entry;
                end
            end

            assign f      = ARITH_W'(r_entry.first);
            assign en     = ARITH_W'(r_entry.range_end);
            assign active = NARROW_W'(i_range_count) > NARROW_W'(i);

            always_comb begin
                if (r_entry.desc) begin
                    in_rng  = (c <= f) && (c > en);
                    clipped = (c <= z) || (s_dn <= en);
                end else begin
                    in_rng  = (c >= f) && (c < en);
                    clipped = (s_up >= en) || (s_up > COLOR_MAX);
                end
            end

            assign ent_hit[i] = active && color_ok && in_rng;
            assign ent_res[i] = clipped ? r_entry.clip :
                                r_entry.desc ? s_dn[COLOR_W-1:0] : s_up[COLOR_W-1:0];
        end else begin : g_pad
            assign ent_hit[i] = 1'b0;
            assign ent_res[i] = '0;
        end
    end

    // first hit inside each group, lowest index wins
    always_comb begin
        n_grp.hit   = '0;
        n_grp.res   = '0;
        n_grp.color = i_pix.pixel_color;
        for (int g = 0; g < GROUPS; g++) begin
            for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
                if (ent_hit[g*GROUP_SIZE + j]) begin
                    n_grp.hit[g] = 1'b1;
                    n_grp.res[g] = ent_res[g*GROUP_SIZE + j];
                end
            end
        end
    end

    // stage one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= accept && (i_pix.action == ACT_MAP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_pix.ready) begin
            r_grp <= n_grp;
        end
    end

    assign o_valid = r_valid;
    assign o_grp   = r_grp;
endmodule

### rtl/prds_merge.sv
module prds_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  prds_pkg::t_grp_bus i_grp,
    output logic               o_ready,
    prds_out_if.source         o_res
);
    import prds_pkg::*;

    localparam int PAD_GROUPS = HALVES * MERGE_FAN;

    logic [PAD_GROUPS-1:0] grp_hit;
    logic [COLOR_W-1:0]    grp_res [PAD_GROUPS];

    logic                  r2_valid;
    logic [HALVES-1:0]     r2_hit;
    logic [COLOR_W-1:0]    r2_res [HALVES];
    logic [COLOR_W-1:0]    r2_color;
    logic [HALVES-1:0]     n2_hit;
    logic [COLOR_W-1:0]    n2_res [HALVES];

    logic                  r3_valid;
    logic [COLOR_W-1:0]    r3_color;
    logic [COLOR_W-1:0]    n3_color;

    logic                  s2_ready;
    logic                  s3_ready;

    // handshake chain
    assign s3_ready = !r3_valid || o_res.ready;
    assign s2_ready = !r2_valid || s3_ready;
    assign o_ready  = s2_ready;

    // pad the group row to a whole number of merge slices
    for (genvar g = 0; g < PAD_GROUPS; g++) begin : g_pad
        if (g < GROUPS) begin : g_used
            assign grp_hit[g] = i_grp.hit[g];
            assign grp_res[g] = i_grp.res[g];
        end else begin : g_none
            assign grp_hit[g] = 1'b0;
            assign grp_res[g] = '0;
        end
    end

    // second level of the priority tree
    always_comb begin
        for (int h = 0; h < HALVES; h++) begin
            n2_hit[h] = 1'b0;
            n2_res[h] = '0;
            for (int k = MERGE_FAN - 1; k >= 0; k--) begin
                if (grp_hit[h*MERGE_FAN + k]) begin
                    n2_hit[h] = 1'b1;
                    n2_res[h] = grp_res[h*MERGE_FAN + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_ready) begin
            r2_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            r2_hit   <= n2_hit;
            r2_res   <= n2_res;
            r2_color <= i_grp.color;
        end
    end

    // last level: first hit, else the colour passes through
    always_comb begin
        n3_color = r2_color;
        for (int h = HALVES - 1; h >= 0; h--) begin
            if (r2_hit[h]) begin
                n3_color = r2_res[h];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (s3_ready) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && r2_valid) begin
            r3_color <= n3_color;
        end
    end

    assign o_res.valid        = r3_valid;
    assign o_res.mapped_color = r3_color;
endmodule

### rtl/prds_checker.sv
`include "palette_range_depth_shader_unit_defines.svh"

module prds_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [prds_pkg::COLOR_W-1:0]    i_out_color,
    input logic                            i_psel,
    input logic                            i_penable,
    input logic                            i_pwrite,
    input logic                            i_pready,
    input logic [prds_pkg::APB_ADDR_W-1:0] i_paddr,
    input logic [prds_pkg::APB_DATA_W-1:0] i_pwdata,
    input logic [prds_pkg::APB_DATA_W-1:0] i_prdata
);
    import prds_pkg::*;

    logic cnt_sel;
    logic cnt_wr;

    assign cnt_sel = i_paddr[APB_ADDR_W-1:2] == REG_RANGE_COUNT;
    assign cnt_wr  = i_psel && i_penable && i_pwrite && i_pready && cnt_sel;

    // a stalled result holds
    `PRDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_color), "stalled result changed")

    // with the output side free the whole pipeline moves
    `PRDS_ASSERT_NOW(a_drain_ready, i_clk, i_rst_n, !i_out_valid || i_out_ready, i_in_ready, "input stalled with free output")

    // range_count reads back what was written
    `PRDS_ASSERT_NOW(a_cnt_readback, i_clk, i_rst_n, $past(i_rst_n) && $past(cnt_wr) && cnt_sel, i_prdata[COUNT_W-1:0] == $past(i_pwdata[COUNT_W-1:0]), "range_count readback wrong")

    // reset empties the output
    `PRDS_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")
endmodule

bind palette_range_depth_shader_unit prds_checker u_prds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_color (o_res.mapped_color),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_pready    (pready),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);
